@@ rtl/core/hevc_nal_unit_scanner_assert.svh @@
// Assertion helpers shared by the scanner RTL.
// Both expect aclk and aresetn in the scope of the module that uses them.
`ifndef HEVC_NAL_UNIT_SCANNER_ASSERT_SVH
`define HEVC_NAL_UNIT_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define HNUS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked at the following edge.
`define HNUS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hnus_pkg.sv @@
package hnus_pkg;

    // start code lengths
    localparam logic [2:0] PREFIX_SHORT = 3'd3;
    localparam logic [2:0] PREFIX_LONG  = 3'd4;

    // header byte bits kept before the type shift
    localparam logic [7:0] HEADER_MASK = 8'h7F;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // one unit record, fields at port widths
    typedef struct packed {
        logic [31:0] unit_start;
        logic [2:0]  prefix_length;
        logic [31:0] header_offset;
        logic [5:0]  unit_type;
        logic [31:0] unit_length;
        logic        final_unit;
    } rec_t;

    // record plus its running type count
    typedef struct packed {
        rec_t        rec;
        logic [31:0] type_total;
    } out_t;

    // records raised by one byte; eos requests clearing the counts
    typedef struct packed {
        logic       eos;
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } req_t;

    // finished records handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        out_t       out0;
        out_t       out1;
    } push_t;

endpackage

@@ rtl/core/hnus_scanner.sv @@
`include "hevc_nal_unit_scanner_assert.svh"

module hnus_scanner #(
    parameter int POSITION_BITS     = 32,
    parameter int START_CODE_MARGIN = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_end_of_stream,
    output logic                req_valid,
    input  logic                req_ready,
    output hnus_pkg::req_t      req
);

    localparam int PB = POSITION_BITS;
    localparam int NEED_SHORT = (START_CODE_MARGIN > 3) ? START_CODE_MARGIN : 3;
    localparam int NEED_LONG  = (START_CODE_MARGIN > 4) ? START_CODE_MARGIN : 4;

    typedef struct packed {
        logic          v;
        logic [PB-1:0] start;
        logic          is_long;
        logic [5:0]    utype;
    } code_t;

    function automatic hnus_pkg::rec_t make_rec(code_t c, logic [PB-1:0] len, logic fin);
        hnus_pkg::rec_t r;
        logic [2:0]     pl;
        logic [PB-1:0]  hdr;
        pl = c.is_long ? hnus_pkg::PREFIX_LONG : hnus_pkg::PREFIX_SHORT;
        hdr = c.start + PB'(pl);
        r.unit_start    = 32'(c.start);
        r.prefix_length = pl;
        r.header_offset = 32'(hdr);
        r.unit_type     = c.utype;
        r.unit_length   = 32'(len);
        r.final_unit    = fin;
        return r;
    endfunction

    logic [7:0]     win0_reg, win1_reg, win2_reg;
    logic [7:0]     win0_next, win1_next, win2_next;
    logic [1:0]     fill_reg, fill_next;
    logic [PB-1:0]  pos_reg, pos_next;
    logic [PB-1:0]  eas_reg, eas_next;
    code_t          pend0_reg, pend1_reg, open_reg;
    code_t          pend0_next, pend1_next, open_next;
    logic           req_valid_reg, req_valid_next;
    hnus_pkg::req_t req_reg, req_next;

    logic           accept;
    logic [PB-1:0]  test_pos, gap, d_a, d_b;
    logic           allowed, long_hit, short_hit, detect, confirm;
    logic [5:0]     hdr_type;
    code_t          new_code, a_raw, b_raw, a_cap, b_cap, open_after;
    logic           has_conf, has_fin;
    hnus_pkg::rec_t rec_conf, rec_fin;

    assign s_ready   = !req_valid_reg || req_ready;
    assign accept    = s_valid && s_ready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    // start code test at the oldest window byte
    always_comb begin
        test_pos  = pos_reg - PB'(3);
        gap       = eas_reg - test_pos;
        allowed   = (fill_reg == 2'd3) && ((gap == '0) || (gap > PB'(4)));
        long_hit  = (win0_reg == 8'd0) && (win1_reg == 8'd0) && (win2_reg == 8'd0)
                    && (s_data_byte == 8'd1);
        short_hit = (win0_reg == 8'd0) && (win1_reg == 8'd0) && (win2_reg == 8'd1);
        detect    = allowed && (long_hit || short_hit);
        hdr_type  = 6'((s_data_byte & hnus_pkg::HEADER_MASK) >> 1);

        new_code.v       = detect;
        new_code.start   = test_pos;
        new_code.is_long = long_hit;
        new_code.utype   = '0;
    end

    // pending list with this beat's code appended; header capture and confirm
    always_comb begin
        a_raw = pend0_reg.v ? pend0_reg : new_code;
        if (!pend0_reg.v) begin
            b_raw = '0;
        end else if (pend1_reg.v) begin
            b_raw = pend1_reg;
        end else begin
            b_raw = new_code;
        end

        d_a = pos_reg - a_raw.start;
        d_b = pos_reg - b_raw.start;

        a_cap = a_raw;
        if (a_raw.v && (d_a == PB'(a_raw.is_long ? hnus_pkg::PREFIX_LONG
                                                 : hnus_pkg::PREFIX_SHORT))) begin
            a_cap.utype = hdr_type;
        end
        b_cap = b_raw;
        if (b_raw.v && (d_b == PB'(b_raw.is_long ? hnus_pkg::PREFIX_LONG
                                                 : hnus_pkg::PREFIX_SHORT))) begin
            b_cap.utype = hdr_type;
        end

        // only the oldest code can reach its confirmation distance
        confirm = a_cap.v && (d_a == (a_cap.is_long ? PB'(NEED_LONG) : PB'(NEED_SHORT)));
        open_after = confirm ? a_cap : open_reg;

        has_conf = confirm && open_reg.v;
        has_fin  = s_end_of_stream && open_after.v;
        rec_conf = make_rec(open_reg, a_cap.start - open_reg.start, 1'b0);
        rec_fin  = make_rec(open_after, pos_reg + PB'(1) - open_after.start, 1'b1);
    end

    // next state
    always_comb begin
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        win2_next  = win2_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        eas_next   = eas_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        open_next  = open_reg;

        req_valid_next = req_ready ? 1'b0 : req_valid_reg;
        req_next       = req_reg;

        if (accept) begin
            if (has_conf || has_fin || s_end_of_stream) begin
                req_valid_next = 1'b1;
                req_next.eos   = s_end_of_stream;
                req_next.count = 2'(has_conf) + 2'(has_fin);
                req_next.rec0  = has_conf ? rec_conf : rec_fin;
                req_next.rec1  = rec_fin;
            end

            if (s_end_of_stream) begin
                win0_next  = '0;
                win1_next  = '0;
                win2_next  = '0;
                fill_next  = '0;
                pos_next   = '0;
                eas_next   = '0;
                pend0_next = '0;
                pend1_next = '0;
                open_next  = '0;
            end else begin
                win0_next  = win1_reg;
                win1_next  = win2_reg;
                win2_next  = s_data_byte;
                fill_next  = (fill_reg == 2'd3) ? fill_reg : fill_reg + 2'd1;
                pos_next   = pos_reg + PB'(1);
                if (detect) begin
                    eas_next = test_pos + (long_hit ? PB'(5) : PB'(4));
                end
                pend0_next = confirm ? b_cap : a_cap;
                pend1_next = confirm ? code_t'('0) : b_cap;
                open_next  = open_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg      <= '0;
            win1_reg      <= '0;
            win2_reg      <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            eas_reg       <= '0;
            pend0_reg     <= '0;
            pend1_reg     <= '0;
            open_reg      <= '0;
            req_valid_reg <= 1'b0;
        end else begin
            win0_reg      <= win0_next;
            win1_reg      <= win1_next;
            win2_reg      <= win2_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            eas_reg       <= eas_next;
            pend0_reg     <= pend0_next;
            pend1_reg     <= pend1_next;
            open_reg      <= open_next;
            req_valid_reg <= req_valid_next;
        end
    end

    // request payload
    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    `HNUS_ASSERT_NOW(a_pend_order, pend1_reg.v, pend0_reg.v, "second pending code without first")
    `HNUS_ASSERT_NEXT(a_eos_clear, accept && s_end_of_stream, !open_reg.v && !pend0_reg.v && (pos_reg == '0), "stream state not cleared after last byte")

endmodule

@@ rtl/core/hnus_type_count.sv @@
`include "hevc_nal_unit_scanner_assert.svh"

module hnus_type_count #(
    parameter int TYPE_SLOTS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            req_valid,
    output logic            req_ready,
    input  hnus_pkg::req_t  req,
    output logic            push_valid,
    input  logic            push_ready,
    output hnus_pkg::push_t push
);

    localparam int AW = $clog2(TYPE_SLOTS);

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == hnus_pkg::COUNT_MAX) ? v : v + 32'd1;
    endfunction

    // count table, one read-modify-write per record
    logic [31:0]           mem [TYPE_SLOTS];
    logic [TYPE_SLOTS-1:0] vld_reg;

    logic           c_valid_reg, c_valid_next;
    hnus_pkg::req_t c_req_reg;
    logic [31:0]    rd0_reg, rd1_reg, fd0_reg, fd1_reg;
    logic           v0_reg, v1_reg, f0_reg, f1_reg;

    logic           xfer, c_adv, clr, we;
    logic [AW-1:0]  ra0, ra1, wa;
    logic [31:0]    wd, cnt0, cnt1, tot0, tot1;

    assign c_adv     = c_valid_reg && push_ready;
    assign req_ready = !c_valid_reg || push_ready;
    assign xfer      = req_valid && req_ready;
    assign clr       = c_adv && c_req_reg.eos;

    assign ra0 = req.rec0.unit_type[AW-1:0];
    assign ra1 = req.rec1.unit_type[AW-1:0];

    // entry not yet written in this stream counts as zero
    always_comb begin
        cnt0 = f0_reg ? fd0_reg : (v0_reg ? rd0_reg : 32'd0);
        cnt1 = f1_reg ? fd1_reg : (v1_reg ? rd1_reg : 32'd0);
        tot0 = sat_inc(cnt0);
        if (c_req_reg.rec1.unit_type == c_req_reg.rec0.unit_type) begin
            tot1 = sat_inc(tot0);
        end else begin
            tot1 = sat_inc(cnt1);
        end
    end

    // the last byte of a stream clears the table, so its records write nothing back
    assign we = c_adv && !c_req_reg.eos && (c_req_reg.count != 2'd0);
    assign wa = c_req_reg.rec0.unit_type[AW-1:0];
    assign wd = tot0;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (xfer) begin
            rd0_reg <= mem[ra0];
            rd1_reg <= mem[ra1];
        end
    end

    // valid bits and forwarding of a write that lands with the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (clr) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[wa] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            v0_reg    <= vld_reg[ra0] && !clr;
            v1_reg    <= vld_reg[ra1] && !clr;
            f0_reg    <= we && (wa == ra0);
            f1_reg    <= we && (wa == ra1);
            fd0_reg   <= wd;
            fd1_reg   <= wd;
            c_req_reg <= req;
        end
    end

    assign c_valid_next = xfer ? 1'b1 : (c_adv ? 1'b0 : c_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
        end
    end

    assign push_valid           = c_valid_reg;
    assign push.count           = c_req_reg.count;
    assign push.out0.rec        = c_req_reg.rec0;
    assign push.out0.type_total = tot0;
    assign push.out1.rec        = c_req_reg.rec1;
    assign push.out1.type_total = tot1;

    `HNUS_ASSERT_NEXT(a_clear_all, clr, vld_reg == '0, "type counts not cleared at stream end")
    `HNUS_ASSERT_NEXT(a_write_marks, we, vld_reg != '0, "count write left no valid entry")

endmodule

@@ rtl/core/hnus_out_fifo.sv @@
module hnus_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  hnus_pkg::push_t push,
    output logic            m_valid,
    input  logic            m_ready,
    output hnus_pkg::out_t  head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    hnus_pkg::out_t q [DEPTH];
    logic [PW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           push_fire, pop;
    logic [1:0]     nwr;

    // room for two records before taking a beat
    assign push_ready = cnt_reg <= CW'(DEPTH - 2);
    assign push_fire  = push_valid && push_ready;
    assign nwr        = push_fire ? push.count : 2'd0;
    assign m_valid    = cnt_reg != '0;
    assign pop        = m_valid && m_ready;
    assign head       = q[rp_reg];

    assign wp_next  = wp_reg + PW'(nwr);
    assign rp_next  = rp_reg + PW'(pop);
    assign cnt_next = cnt_reg + CW'(nwr) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (nwr != 2'd0) begin
            q[wp_reg] <= push.out0;
        end
        if (nwr == 2'd2) begin
            q[wp_reg + PW'(1)] <= push.out1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/hevc_nal_unit_scanner.sv @@
// Annex B start code scanner: takes one stream byte per clock while s_ready is high and
// returns one record per NAL unit. Records pass the request register, the count stage
// and the output queue after the byte that completes them (the byte that confirms the
// next start code, or the byte flagged end_of_stream, which may release two records).
// The per-type totals live in a 64-entry table read as a request enters the count stage
// and written back from it, with a write landing on the entry being read forwarded; valid
// bits clear it at once at the end of each stream, so there is no clearing pass after
// reset. Input ready drops only when the four-record output queue cannot take two more.
module hevc_nal_unit_scanner #(
    parameter int POSITION_BITS     = 32,
    parameter int TYPE_SLOTS        = 64,
    parameter int START_CODE_MARGIN = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_unit_start,
    output logic [2:0]  m_prefix_length,
    output logic [31:0] m_header_offset,
    output logic [5:0]  m_unit_type,
    output logic [31:0] m_unit_length,
    output logic [31:0] m_type_total,
    output logic        m_final_unit
);

    logic            req_valid, req_ready, push_valid, push_ready;
    hnus_pkg::req_t  req;
    hnus_pkg::push_t push;
    hnus_pkg::out_t  head;

    // start code search and unit tracking
    hnus_scanner #(
        .POSITION_BITS     (POSITION_BITS),
        .START_CODE_MARGIN (START_CODE_MARGIN)
    ) u_scanner (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req)
    );

    // per-type running totals
    hnus_type_count #(
        .TYPE_SLOTS (TYPE_SLOTS)
    ) u_type_count (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push       (push)
    );

    // record queue toward the result channel
    hnus_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push       (push),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_unit_start    = head.rec.unit_start;
    assign m_prefix_length = head.rec.prefix_length;
    assign m_header_offset = head.rec.header_offset;
    assign m_unit_type     = head.rec.unit_type;
    assign m_unit_length   = head.rec.unit_length;
    assign m_type_total    = head.type_total;
    assign m_final_unit    = head.rec.final_unit;

endmodule
